// File: rtl/rpn_pkg.sv
package rpn_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int WORD_W = 32;
   localparam int LIT_W = 30;
   localparam int DEPTH_W = 7;
   localparam int STATUS_W = 3;

   // command codes
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_OPER = 2'd1;
   localparam logic [1:0] CMD_POP = 2'd2;

   // operator characters
   localparam logic [7:0] OP_ADD = 8'h2B;
   localparam logic [7:0] OP_SUB = 8'h2D;
   localparam logic [7:0] OP_MUL = 8'h2A;
   localparam logic [7:0] OP_DIV = 8'h2F;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BADOP = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DIVZ = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL = 3'd4;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_ABOVE,
      CELL_TAKE_BELOW,
      CELL_TAKE_RESULT
   } cell_mode_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL = 4'b0010,
      S_DIV = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

endpackage

// File: rtl/rpn_cell.sv
module rpn_cell (
   input  logic                            clock,
   input  rpn_pkg::cell_mode_type          mode,
   input  logic [rpn_pkg::WORD_W-1:0]      above,
   input  logic [rpn_pkg::WORD_W-1:0]      below,
   input  logic [rpn_pkg::WORD_W-1:0]      result,
   output logic [rpn_pkg::WORD_W-1:0]      data
);
   import rpn_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      case (mode)
         CELL_TAKE_ABOVE:  data_in = above;
         CELL_TAKE_BELOW:  data_in = below;
         CELL_TAKE_RESULT: data_in = result;
         default:          data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: rtl/rpn_div.sv
module rpn_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rpn_pkg::WORD_W-1:0]      dividend,
   input  logic [rpn_pkg::WORD_W-1:0]      divisor,
   output logic                            done,
   output logic [rpn_pkg::WORD_W-1:0]      quotient
);
   import rpn_pkg::*;

   localparam int STEPS = WORD_W;
   localparam int STEP_W = $clog2(STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   quo_ff, quo_in;
   logic [WORD_W-1:0]   dsr_ff, dsr_in;
   logic                neg_ff, neg_in;
   logic [WORD_W:0]     trial;

   // one quotient bit per cycle on magnitudes, restoring
   assign trial = {rem_ff, quo_ff[WORD_W-1]} - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         quo_in = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
         dsr_in = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
         neg_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (WORD_W'(0) - quo_ff) : quo_ff;

endmodule

// File: rtl/rpn_integer_stack_calculator.sv
// Postfix integer calculator over a stack of 32-bit words held in a row of
// cells, top of stack in cell zero; every push, pop or operator shifts the whole
// row by one place. One request is processed at a time: push, pop, add,
// subtract and all error cases go from idle straight to the finish state,
// multiply passes through a multiply state, and divide waits in a divide
// state for the 32-step iterative divider that produces one quotient bit per
// cycle. The finish state raises the response once the response register is
// free, so a stalled response holds it there. A finished result is held in the
// response register while the next request is accepted. Errors (status
// underflow, invalid operator, divide by zero, stack full) leave the stack as
// it was and return value zero; depth reports the word count after the request.
module rpn_integer_stack_calculator #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [rpn_pkg::LIT_W-1:0]           req_literal,
   input  logic [7:0]                          req_op_char,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rpn_pkg::WORD_W-1:0]   rsp_value,
   output logic [rpn_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rpn_pkg::DEPTH_W-1:0]         rsp_depth
);
   import rpn_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [LIT_W-1:0]        lit_ff, lit_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [WORD_W-1:0]       result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DEPTH_W-1:0]      rsp_depth_ff, rsp_depth_in;

   logic [WORD_W-1:0]       cell_data [STACK_DEPTH];
   logic [WORD_W-1:0]       top_word, next_word;
   logic [WORD_W-1:0]       product;
   logic                    accept, out_free, fire, div_start, div_done;
   logic [WORD_W-1:0]       div_quot;
   logic [STATUS_W-1:0]     req_status;
   cell_mode_type           mode_top, mode_rest;

   assign top_word = cell_data[0];
   assign next_word = cell_data[1];
   assign product = top_word * next_word;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire = (state_ff == S_FINISH) && out_free;
   assign div_start = accept && (req_cmd == CMD_OPER) && (req_op_char == OP_DIV)
                      && (req_status == STAT_OK);

   // classify the incoming request against the current stack
   always_comb begin
      case (req_cmd)
         CMD_PUSH: begin
            req_status = (count_ff >= CNT_W'(STACK_DEPTH)) ? STAT_FULL : STAT_OK;
         end
         CMD_OPER: begin
            if (count_ff < CNT_W'(2)) begin
               req_status = STAT_UNDER;
            end else if (req_op_char inside {OP_ADD, OP_SUB, OP_MUL}) begin
               req_status = STAT_OK;
            end else if (req_op_char == OP_DIV) begin
               req_status = (top_word == '0) ? STAT_DIVZ : STAT_OK;
            end else begin
               req_status = STAT_BADOP;
            end
         end
         CMD_POP: begin
            req_status = (count_ff == '0) ? STAT_UNDER : STAT_OK;
         end
         default: req_status = STAT_BADOP;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      lit_in = lit_ff;
      status_in = status_ff;
      result_in = result_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               lit_in = req_literal;
               status_in = req_status;
               result_in = '0;
               state_in = S_FINISH;
               if ((req_cmd == CMD_OPER) && (req_status == STAT_OK)) begin
                  case (req_op_char)
                     OP_ADD:  result_in = next_word + top_word;
                     OP_SUB:  result_in = next_word - top_word;
                     OP_MUL:  state_in = S_MUL;
                     OP_DIV:  state_in = S_DIV;
                     default: result_in = '0;
                  endcase
               end
            end
         end
         S_MUL: begin
            result_in = product;
            state_in = S_FINISH;
         end
         S_DIV: begin
            if (div_done) begin
               result_in = div_quot;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commit the stack change together with the response
   always_comb begin
      count_in = count_ff;
      mode_top = CELL_HOLD;
      mode_rest = CELL_HOLD;
      if (fire && (status_ff == STAT_OK)) begin
         case (cmd_ff)
            CMD_PUSH: begin
               count_in = count_ff + 1'b1;
               mode_top = CELL_TAKE_ABOVE;
               mode_rest = CELL_TAKE_ABOVE;
            end
            CMD_OPER: begin
               count_in = count_ff - 1'b1;
               mode_top = CELL_TAKE_RESULT;
               mode_rest = CELL_TAKE_BELOW;
            end
            CMD_POP: begin
               count_in = count_ff - 1'b1;
               mode_top = CELL_TAKE_BELOW;
               mode_rest = CELL_TAKE_BELOW;
            end
            default: count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in = rsp_depth_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = status_ff;
         rsp_depth_in = DEPTH_W'(count_in);
         rsp_value_in = '0;
         if (status_ff == STAT_OK) begin
            if (cmd_ff == CMD_OPER) begin
               rsp_value_in = result_ff;
            end else if (cmd_ff == CMD_POP) begin
               rsp_value_in = top_word;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      lit_ff <= lit_in;
      status_ff <= status_in;
      result_ff <= result_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] above;
      logic [WORD_W-1:0] below;
      cell_mode_type     mode;
      if (i == 0) begin : g_top
         assign above = WORD_W'(lit_ff);
         assign mode = mode_top;
      end else begin : g_inner
         assign above = cell_data[i-1];
         assign mode = mode_rest;
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = '0;
      end else begin : g_link
         assign below = cell_data[i+1];
      end
      rpn_cell u_cell (
         .clock  (clock),
         .mode   (mode),
         .above  (above),
         .below  (below),
         .result (result_ff),
         .data   (cell_data[i])
      );
   end

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (next_word),
      .divisor  (top_word),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_depth = rsp_depth_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted but controller stayed idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (fire && (status_ff == STAT_OK) && (cmd_ff == CMD_PUSH))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("good push did not grow the stack");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (fire && (status_ff != STAT_OK)) |=> $stable(count_ff))
      else $error("error response changed the stack count");

endmodule
